// ===== src/button_touch_gesture_qualifier_core_macros.svh =====
// Assertion macros shared by the gesture qualifier RTL.
// Used by btgq_div and the core top level; no other dependencies.
`ifndef BUTTON_TOUCH_GESTURE_QUALIFIER_CORE_MACROS_SVH
`define BUTTON_TOUCH_GESTURE_QUALIFIER_CORE_MACROS_SVH

// Same-cycle implication, disabled during reset.
`define BTGQ_ASSERT_IMP(lbl, ck, rn, ante, cons) \
	lbl: assert property (@(posedge ck) disable iff (!rn) (ante) |-> (cons)) \
		else $error("btgq: same-cycle check failed");

// Next-cycle implication, disabled during reset.
`define BTGQ_ASSERT_NXT(lbl, ck, rn, ante, cons) \
	lbl: assert property (@(posedge ck) disable iff (!rn) (ante) |=> (cons)) \
		else $error("btgq: next-cycle check failed");

`endif

// ===== src/btgq_pkg.sv =====
// Shared types and constants for the button/touch gesture qualifier.
// No dependencies; used by btgq_div, btgq_track and the core top level.
`timescale 1ns / 1ps

package btgq_pkg;

	localparam int KEY_W   = 14;
	localparam int CODE_W  = 18;
	localparam int PIX_W   = 8;
	localparam int TILE_W  = 6;
	localparam int CNT_W   = 8;
	localparam int DELTA_W = 9;
	localparam int FLAG_W  = 6;

	// Raw key bit positions
	localparam int BIT_PAD_RIGHT    = 4;
	localparam int BIT_PAD_LEFT     = 5;
	localparam int BIT_PAD_UP       = 6;
	localparam int BIT_PAD_DOWN     = 7;
	localparam int BIT_SCREEN_TOUCH = 12;

	// Diagonal codes
	localparam logic [CODE_W-1:0] CODE_UP_LEFT    = 18'h04000;
	localparam logic [CODE_W-1:0] CODE_UP_RIGHT   = 18'h08000;
	localparam logic [CODE_W-1:0] CODE_DOWN_LEFT  = 18'h10000;
	localparam logic [CODE_W-1:0] CODE_DOWN_RIGHT = 18'h20000;

	// Internal gesture state bits
	localparam int GB_DRAG  = 0;
	localparam int GB_START = 1;
	localparam int GB_STOP  = 2;
	localparam int GB_HOLD  = 3;

	// Output flag bits
	localparam int GF_TOUCH = 0;
	localparam int GF_DRAG  = 1;
	localparam int GF_START = 2;
	localparam int GF_STOP  = 3;
	localparam int GF_TAP   = 4;
	localparam int GF_HOLD  = 5;

	typedef enum logic [1:0] {
		CFG_TILE_WIDTH  = 2'd0,
		CFG_TILE_HEIGHT = 2'd1,
		CFG_KEY_HOLD    = 2'd2,
		CFG_TOUCH_HOLD  = 2'd3
	} cfg_idx_t;

	typedef struct packed {
		logic [KEY_W-1:0] keys_held;
		logic [KEY_W-1:0] keys_up;
		logic             tap_valid;
	} frame_t;

	typedef struct packed {
		logic [PIX_W-1:0] touch_col;
		logic [PIX_W-1:0] touch_row;
		logic [PIX_W-1:0] tap_col;
		logic [PIX_W-1:0] tap_row;
	} cells_t;

	typedef struct packed {
		logic [CNT_W-1:0] key_hold;
		logic [CNT_W-1:0] touch_hold;
	} thr_t;

	typedef struct packed {
		logic [FLAG_W-1:0]         gesture_flags;
		logic [PIX_W-1:0]          tap_row;
		logic [PIX_W-1:0]          tap_col;
		logic signed [DELTA_W-1:0] drag_dy;
		logic signed [DELTA_W-1:0] drag_dx;
		logic [PIX_W-1:0]          touch_row;
		logic [PIX_W-1:0]          touch_col;
		logic [KEY_W-1:0]          released_keys;
		logic [CODE_W-1:0]         pressed_code;
		logic [CODE_W-1:0]         held_code;
	} res_t;

	localparam int RES_W = $bits(res_t);

endpackage

// ===== src/btgq_div.sv =====
// Serial 8-by-6-bit unsigned divider, two quotient bits per cycle.
// Depends on btgq_pkg and the core assertion macro header.
`timescale 1ns / 1ps
`include "button_touch_gesture_qualifier_core_macros.svh"

module btgq_div (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             start,
	input  logic [btgq_pkg::PIX_W-1:0]       dividend,
	input  logic [btgq_pkg::TILE_W-1:0]      divisor,
	output logic                             done,
	output logic [btgq_pkg::PIX_W-1:0]       quotient
);

	logic [btgq_pkg::TILE_W-1:0] rem_q;
	logic [btgq_pkg::PIX_W-1:0]  quo_q;
	logic [btgq_pkg::TILE_W-1:0] div_q;
	logic [1:0]                  cnt_q;
	logic                        busy_q;
	logic                        done_q;
	logic [13:0]                 st1;
	logic [13:0]                 st2;

	// One restoring step: shift in the next dividend bit, subtract if it fits.
	function automatic logic [13:0] div_step(input logic [5:0] r, input logic [7:0] q,
		input logic [5:0] d);
		logic [6:0] t;
		logic [6:0] diff;
		logic [5:0] rn;
		logic       b;
		t    = {r, q[7]};
		diff = t - {1'b0, d};
		if (t >= {1'b0, d}) begin
			rn = diff[5:0];
			b  = 1'b1;
		end else begin
			rn = t[5:0];
			b  = 1'b0;
		end
		return {rn, q[6:0], b};
	endfunction

	always_comb begin
		st1 = div_step(rem_q, quo_q, div_q);
		st2 = div_step(st1[13:8], st1[7:0], div_q);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else if (start) begin
			busy_q <= 1'b1;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else if (busy_q) begin
			cnt_q <= cnt_q + 2'd1;
			if (cnt_q == 2'd3) begin
				busy_q <= 1'b0;
				done_q <= 1'b1;
			end
		end else begin
			done_q <= 1'b0;
		end
	end

	// Datapath registers need no reset.
	always_ff @(posedge clk) begin
		if (start) begin
			rem_q <= '0;
			quo_q <= dividend;
			div_q <= (divisor == '0) ? 6'd1 : divisor;
		end else if (busy_q) begin
			rem_q <= st2[13:8];
			quo_q <= st2[7:0];
		end
	end

	assign done     = done_q;
	assign quotient = quo_q;

	`BTGQ_ASSERT_IMP(a_start_idle, clk, arst_n, start, !busy_q)
	`BTGQ_ASSERT_NXT(a_start_busy, clk, arst_n, start, busy_q && !done_q)
	`BTGQ_ASSERT_IMP(a_done_not_busy, clk, arst_n, done_q, !busy_q)

endmodule

// ===== src/btgq_track.sv =====
// Frame state tracker: key press qualification, drag, tap and hold state.
// Depends on btgq_pkg; commits one frame of state on each update strobe.
`timescale 1ns / 1ps

module btgq_track (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              upd,
	input  btgq_pkg::frame_t  frame,
	input  btgq_pkg::cells_t  cells,
	input  btgq_pkg::thr_t    thr,
	output btgq_pkg::res_t    res
);

	logic [btgq_pkg::CODE_W-1:0]  last_held_q, last_pressed_q;
	logic [btgq_pkg::CNT_W-1:0]   key_cnt_q, touch_cnt_q;
	logic                         was_touching_q;
	logic [btgq_pkg::PIX_W-1:0]   cur_col_q, cur_row_q, start_col_q, start_row_q;
	logic [btgq_pkg::DELTA_W-1:0] dx_q, dy_q;
	logic [btgq_pkg::PIX_W-1:0]   tap_col_q, tap_row_q;
	logic [3:0]                   gbits_q;

	logic                         touching;
	logic [btgq_pkg::PIX_W-1:0]   cur_col_n, cur_row_n, start_col_n, start_row_n;
	logic [btgq_pkg::DELTA_W-1:0] dx_n, dy_n;
	logic [btgq_pkg::PIX_W-1:0]   tap_col_n, tap_row_n;
	logic [3:0]                   g;
	logic [btgq_pkg::CODE_W-1:0]  held, pressed_n;
	logic [btgq_pkg::CNT_W-1:0]   key_cnt_n, touch_cnt_n;
	logic                         moved, tapped;

	always_comb begin
		touching    = frame.keys_held[btgq_pkg::BIT_SCREEN_TOUCH];
		cur_col_n   = touching ? cells.touch_col : cur_col_q;
		cur_row_n   = touching ? cells.touch_row : cur_row_q;
		start_col_n = (touching && !was_touching_q) ? cells.touch_col : start_col_q;
		start_row_n = (touching && !was_touching_q) ? cells.touch_row : start_row_q;
		moved = was_touching_q && touching &&
			((start_col_n != cur_col_n) || (start_row_n != cur_row_n));

		g    = gbits_q;
		dx_n = dx_q;
		dy_n = dy_q;
		if (moved) begin
			dx_n = {1'b0, start_col_n} - {1'b0, cur_col_n};
			dy_n = {1'b0, start_row_n} - {1'b0, cur_row_n};
			if (!g[btgq_pkg::GB_DRAG]) begin
				g[btgq_pkg::GB_DRAG]  = 1'b1;
				g[btgq_pkg::GB_START] = 1'b1;
			end else begin
				g[btgq_pkg::GB_START] = 1'b0;
			end
		end else if (g[btgq_pkg::GB_DRAG]) begin
			g[btgq_pkg::GB_DRAG] = 1'b0;
			g[btgq_pkg::GB_STOP] = 1'b1;
		end else begin
			g[btgq_pkg::GB_STOP] = 1'b0;
		end

		// Diagonal remap, first match wins
		if (frame.keys_held[btgq_pkg::BIT_PAD_UP] && frame.keys_held[btgq_pkg::BIT_PAD_LEFT])
			held = btgq_pkg::CODE_UP_LEFT;
		else if (frame.keys_held[btgq_pkg::BIT_PAD_UP] &&
				frame.keys_held[btgq_pkg::BIT_PAD_RIGHT])
			held = btgq_pkg::CODE_UP_RIGHT;
		else if (frame.keys_held[btgq_pkg::BIT_PAD_DOWN] &&
				frame.keys_held[btgq_pkg::BIT_PAD_LEFT])
			held = btgq_pkg::CODE_DOWN_LEFT;
		else if (frame.keys_held[btgq_pkg::BIT_PAD_DOWN] &&
				frame.keys_held[btgq_pkg::BIT_PAD_RIGHT])
			held = btgq_pkg::CODE_DOWN_RIGHT;
		else
			held = {4'b0, frame.keys_held};

		if ((last_held_q != '0) && (held != '0) && (last_held_q == held)) begin
			key_cnt_n = (key_cnt_q == 8'hFF) ? key_cnt_q : key_cnt_q + 8'd1;
			pressed_n = (key_cnt_n > thr.key_hold) ? held : last_pressed_q;
		end else begin
			key_cnt_n = '0;
			pressed_n = '0;
		end

		tapped = frame.tap_valid && !gbits_q[btgq_pkg::GB_HOLD] &&
			!g[btgq_pkg::GB_DRAG] && !g[btgq_pkg::GB_STOP];
		tap_col_n = frame.tap_valid ? cells.tap_col : tap_col_q;
		tap_row_n = frame.tap_valid ? cells.tap_row : tap_row_q;

		if (touching && !g[btgq_pkg::GB_DRAG]) begin
			touch_cnt_n = (touch_cnt_q == 8'hFF) ? touch_cnt_q : touch_cnt_q + 8'd1;
			if (touch_cnt_n > thr.touch_hold)
				g[btgq_pkg::GB_HOLD] = 1'b1;
		end else begin
			touch_cnt_n          = '0;
			g[btgq_pkg::GB_HOLD] = 1'b0;
		end

		res.held_code     = held;
		res.pressed_code  = pressed_n;
		res.released_keys = frame.keys_up;
		res.touch_col     = cur_col_n;
		res.touch_row     = cur_row_n;
		res.drag_dx       = dx_n;
		res.drag_dy       = dy_n;
		res.tap_col       = tap_col_n;
		res.tap_row       = tap_row_n;
		res.gesture_flags[btgq_pkg::GF_TOUCH] = touching;
		res.gesture_flags[btgq_pkg::GF_DRAG]  = g[btgq_pkg::GB_DRAG];
		res.gesture_flags[btgq_pkg::GF_START] = g[btgq_pkg::GB_START];
		res.gesture_flags[btgq_pkg::GF_STOP]  = g[btgq_pkg::GB_STOP];
		res.gesture_flags[btgq_pkg::GF_TAP]   = tapped;
		res.gesture_flags[btgq_pkg::GF_HOLD]  = g[btgq_pkg::GB_HOLD];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			last_held_q    <= '0;
			last_pressed_q <= '0;
			key_cnt_q      <= '0;
			touch_cnt_q    <= '0;
			was_touching_q <= 1'b0;
			cur_col_q      <= '0;
			cur_row_q      <= '0;
			start_col_q    <= '0;
			start_row_q    <= '0;
			dx_q           <= '0;
			dy_q           <= '0;
			tap_col_q      <= '0;
			tap_row_q      <= '0;
			gbits_q        <= '0;
		end else if (upd) begin
			last_held_q    <= held;
			last_pressed_q <= pressed_n;
			key_cnt_q      <= key_cnt_n;
			touch_cnt_q    <= touch_cnt_n;
			was_touching_q <= touching;
			cur_col_q      <= cur_col_n;
			cur_row_q      <= cur_row_n;
			start_col_q    <= start_col_n;
			start_row_q    <= start_row_n;
			dx_q           <= dx_n;
			dy_q           <= dy_n;
			tap_col_q      <= tap_col_n;
			tap_row_q      <= tap_row_n;
			gbits_q        <= g;
		end
	end

endmodule

// ===== src/button_touch_gesture_qualifier_core.sv =====
// Top level of the button/touch gesture qualifier: stream ports, config
// registers, divide sequencer. Depends on btgq_pkg, btgq_div, btgq_track.
`timescale 1ns / 1ps
`include "button_touch_gesture_qualifier_core_macros.svh"

//  channel | direction | handshake          | payload
//  --------+-----------+--------------------+------------------------------
//  s_*     | in        | s_tvalid/s_tready  | one frame: keys, touch, tap
//  m_*     | out       | m_tvalid/m_tready  | one result per frame
//  cfg_*   | in        | cfg_valid/cfg_ready| register index and data
//
// A frame runs four cell divisions in turn on the shared serial divider (each
// a launch, busy steps at two quotient bits per cycle, and done overlapping
// the next launch), then one state update; no new frame is taken until the
// sequencer is back in idle and ready for the next transfer.
// The result waits in the output register; the next frame is taken while it
// waits, and only the update of that next frame stalls on m_tready.
// arst_n clears control state, frame state and loads the register defaults.
// Config writes are always taken (cfg_ready is tied high).

module button_touch_gesture_qualifier_core (
	input  logic         clk,
	input  logic         arst_n,
	// slave: [13:0] keys_held, [27:14] keys_up, [35:28] touch_x,
	//        [43:36] touch_y, [51:44] tap_x, [59:52] tap_y, rest zero
	input  logic         s_tvalid,
	output logic         s_tready,
	input  logic [63:0]  s_tdata,
	input  logic         s_tuser,  // [0] tap_valid
	// master: [17:0] held_code, [35:18] pressed_code, [49:36] released_keys,
	//         [57:50] touch_col, [65:58] touch_row, [74:66] drag_dx,
	//         [83:75] drag_dy, [91:84] tap_col, [99:92] tap_row,
	//         [105:100] gesture_flags, rest zero
	output logic         m_tvalid,
	input  logic         m_tready,
	output logic [111:0] m_tdata,
	// configuration write channel
	input  logic         cfg_valid,
	output logic         cfg_ready,
	input  logic [1:0]   cfg_index,
	input  logic [7:0]   cfg_data
);

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_DIV,
		ST_UPD
	} state_t;

	typedef enum logic [1:0] {
		OP_TOUCH_X = 2'd0,
		OP_TOUCH_Y = 2'd1,
		OP_TAP_X   = 2'd2,
		OP_TAP_Y   = 2'd3
	} op_t;

	state_t                          state_q;
	op_t                             op_q;
	op_t                             next_op;
	btgq_pkg::frame_t                frame_q;
	logic [btgq_pkg::PIX_W-1:0]      touch_y_q, tap_x_q, tap_y_q;
	btgq_pkg::cells_t                cells_q;
	logic [btgq_pkg::TILE_W-1:0]     tile_width_q, tile_height_q;
	btgq_pkg::thr_t                  thr_q;
	logic                            m_tvalid_q;
	logic [111:0]                    m_tdata_q;

	logic                            s_accept;
	logic                            div_start, div_done;
	logic [btgq_pkg::PIX_W-1:0]      div_dividend, div_quotient;
	logic [btgq_pkg::TILE_W-1:0]     div_divisor;
	logic                            upd;
	btgq_pkg::res_t                  res;

	assign s_tready  = (state_q == ST_IDLE);
	assign s_accept  = s_tvalid && s_tready;
	assign cfg_ready = 1'b1;

	// Launch the touch x division on the transfer itself, then chain each
	// following division off the previous one's done pulse.
	assign next_op   = s_accept ? OP_TOUCH_X : op_t'(op_q + 2'd1);
	assign div_start = s_accept || ((state_q == ST_DIV) && div_done && (op_q != OP_TAP_Y));

	always_comb begin
		case (next_op)
			OP_TOUCH_X: begin
				div_dividend = s_tdata[35:28];
				div_divisor  = tile_width_q;
			end
			OP_TOUCH_Y: begin
				div_dividend = touch_y_q;
				div_divisor  = tile_height_q;
			end
			OP_TAP_X: begin
				div_dividend = tap_x_q;
				div_divisor  = tile_width_q;
			end
			OP_TAP_Y: begin
				div_dividend = tap_y_q;
				div_divisor  = tile_height_q;
			end
			default: begin
				div_dividend = '0;
				div_divisor  = tile_width_q;
			end
		endcase
	end

	// Update fires once all cells are in and the output slot is free.
	assign upd = (state_q == ST_UPD) && (!m_tvalid_q || m_tready);

	btgq_div u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (div_start),
		.dividend (div_dividend),
		.divisor  (div_divisor),
		.done     (div_done),
		.quotient (div_quotient)
	);

	btgq_track u_track (
		.clk    (clk),
		.arst_n (arst_n),
		.upd    (upd),
		.frame  (frame_q),
		.cells  (cells_q),
		.thr    (thr_q),
		.res    (res)
	);

	// Configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tile_width_q     <= 6'd8;
			tile_height_q    <= 6'd8;
			thr_q.key_hold   <= 8'd3;
			thr_q.touch_hold <= 8'd15;
		end else if (cfg_valid && cfg_ready) begin
			case (btgq_pkg::cfg_idx_t'(cfg_index))
				btgq_pkg::CFG_TILE_WIDTH:  tile_width_q     <= cfg_data[5:0];
				btgq_pkg::CFG_TILE_HEIGHT: tile_height_q    <= cfg_data[5:0];
				btgq_pkg::CFG_KEY_HOLD:    thr_q.key_hold   <= cfg_data;
				btgq_pkg::CFG_TOUCH_HOLD:  thr_q.touch_hold <= cfg_data;
				default: ;
			endcase
		end
	end

	// Capture the frame payload on transfer; hold it for the whole run.
	always_ff @(posedge clk) begin
		if (s_accept) begin
			frame_q.keys_held <= s_tdata[13:0];
			frame_q.keys_up   <= s_tdata[27:14];
			frame_q.tap_valid <= s_tuser;
			touch_y_q         <= s_tdata[43:36];
			tap_x_q           <= s_tdata[51:44];
			tap_y_q           <= s_tdata[59:52];
		end
		if ((state_q == ST_DIV) && div_done) begin
			case (op_q)
				OP_TOUCH_X: cells_q.touch_col <= div_quotient;
				OP_TOUCH_Y: cells_q.touch_row <= div_quotient;
				OP_TAP_X:   cells_q.tap_col   <= div_quotient;
				OP_TAP_Y:   cells_q.tap_row   <= div_quotient;
				default: ;
			endcase
		end
	end

	// Sequencer and output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= ST_IDLE;
			op_q       <= OP_TOUCH_X;
			m_tvalid_q <= 1'b0;
			m_tdata_q  <= '0;
		end else begin
			if (m_tvalid_q && m_tready && !upd)
				m_tvalid_q <= 1'b0;
			case (state_q)
				ST_IDLE: begin
					if (s_accept) begin
						op_q    <= OP_TOUCH_X;
						state_q <= ST_DIV;
					end
				end
				ST_DIV: begin
					if (div_done) begin
						if (op_q == OP_TAP_Y)
							state_q <= ST_UPD;
						else
							op_q <= next_op;
					end
				end
				ST_UPD: begin
					if (upd) begin
						m_tvalid_q <= 1'b1;
						m_tdata_q  <= {6'b0, res};
						state_q    <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	assign m_tvalid = m_tvalid_q;
	assign m_tdata  = m_tdata_q;

	`BTGQ_ASSERT_NXT(a_busy_after_accept, clk, arst_n, s_accept, !s_tready)
	`BTGQ_ASSERT_NXT(a_result_after_update, clk, arst_n, upd, m_tvalid)
	`BTGQ_ASSERT_IMP(a_done_in_div, clk, arst_n, div_done, state_q == ST_DIV)

endmodule

// ===== tb/btgq_result_checker.sv =====
// Result checker for the button/touch gesture qualifier: models each frame and
// compares every output transfer with the oldest predicted result.
// Depends on btgq_pkg for widths, key/flag positions and register indexes.
`timescale 1ns / 1ps

module btgq_result_checker
	import btgq_pkg::*;
(
	input  logic         clk,
	input  logic         arst_n,
	input  logic         s_tvalid,
	input  logic         s_tready,
	input  logic [63:0]  s_tdata,
	input  logic         s_tuser,
	input  logic         m_tvalid,
	input  logic         m_tready,
	input  logic [111:0] m_tdata,
	input  logic         cfg_valid,
	input  logic         cfg_ready,
	input  logic [1:0]   cfg_index,
	input  logic [7:0]   cfg_data,
	output int           mismatch_count,
	output int           outstanding
);

	// register copies
	logic [TILE_W-1:0] tile_w, tile_h;
	logic [CNT_W-1:0]  key_thr, hold_thr;

	// frame state
	logic [CODE_W-1:0]  prev_code, press_code;
	logic [CNT_W-1:0]   key_run, still_run;
	logic               touch_prev;
	logic [PIX_W-1:0]   col_now, row_now, col_origin, row_origin;
	logic [PIX_W-1:0]   tap_cell_col, tap_cell_row;
	logic [DELTA_W-1:0] delta_x, delta_y;
	logic               dragging, drag_begun, drag_ended, holding;

	res_t predicted_results[$];
	res_t want_res, got_res;

	function automatic logic [PIX_W-1:0] pixel_to_cell(input logic [PIX_W-1:0] pix,
			input logic [TILE_W-1:0] size);
		logic [TILE_W-1:0] d;
		d = (size == '0) ? TILE_W'(1) : size;
		return pix / d;
	endfunction

	// Diagonal pairs collapse to one code bit, tested in priority order.
	function automatic logic [CODE_W-1:0] remap_pad(input logic [KEY_W-1:0] k);
		if (k[BIT_PAD_UP] && k[BIT_PAD_LEFT])
			return CODE_UP_LEFT;
		if (k[BIT_PAD_UP] && k[BIT_PAD_RIGHT])
			return CODE_UP_RIGHT;
		if (k[BIT_PAD_DOWN] && k[BIT_PAD_LEFT])
			return CODE_DOWN_LEFT;
		if (k[BIT_PAD_DOWN] && k[BIT_PAD_RIGHT])
			return CODE_DOWN_RIGHT;
		return CODE_W'(k);
	endfunction

	function automatic res_t qualify_frame(input logic [63:0] d, input logic tap_valid);
		logic [KEY_W-1:0]  raw;
		logic [PIX_W-1:0]  tx, ty, px, py;
		logic [CODE_W-1:0] code;
		logic              touching, hold_before, tapped;
		res_t              r;
		raw = d[13:0];
		tx = d[35:28];
		ty = d[43:36];
		px = d[51:44];
		py = d[59:52];
		touching = raw[BIT_SCREEN_TOUCH];
		hold_before = holding;

		if (touching) begin
			col_now = pixel_to_cell(tx, tile_w);
			row_now = pixel_to_cell(ty, tile_h);
			if (!touch_prev) begin
				col_origin = col_now;
				row_origin = row_now;
			end
		end

		if (touch_prev && touching && (col_origin != col_now || row_origin != row_now)) begin
			delta_x = {1'b0, col_origin} - {1'b0, col_now};
			delta_y = {1'b0, row_origin} - {1'b0, row_now};
			if (!dragging) begin
				dragging = 1'b1;
				drag_begun = 1'b1;
			end else
				drag_begun = 1'b0;
		end else if (dragging) begin
			dragging = 1'b0;
			drag_ended = 1'b1;
		end else
			drag_ended = 1'b0;

		code = remap_pad(raw);
		if (prev_code != '0 && code != '0 && prev_code == code) begin
			key_run = (key_run == '1) ? key_run : key_run + 1'b1;
			if (key_run > key_thr)
				press_code = code;
		end else begin
			press_code = '0;
			key_run = '0;
		end
		prev_code = code;

		tapped = tap_valid && !hold_before && !dragging && !drag_ended;
		if (tap_valid) begin
			tap_cell_col = pixel_to_cell(px, tile_w);
			tap_cell_row = pixel_to_cell(py, tile_h);
		end

		if (touching && !dragging) begin
			still_run = (still_run == '1) ? still_run : still_run + 1'b1;
			if (still_run > hold_thr)
				holding = 1'b1;
		end else begin
			holding = 1'b0;
			still_run = '0;
		end
		touch_prev = touching;

		r = '0;
		r.held_code = code;
		r.pressed_code = press_code;
		r.released_keys = d[27:14];
		r.touch_col = col_now;
		r.touch_row = row_now;
		r.drag_dx = delta_x;
		r.drag_dy = delta_y;
		r.tap_col = tap_cell_col;
		r.tap_row = tap_cell_row;
		r.gesture_flags[GF_TOUCH] = touching;
		r.gesture_flags[GF_DRAG] = dragging;
		r.gesture_flags[GF_START] = drag_begun;
		r.gesture_flags[GF_STOP] = drag_ended;
		r.gesture_flags[GF_TAP] = tapped;
		r.gesture_flags[GF_HOLD] = holding;
		return r;
	endfunction

	task automatic check_field(input string name, input logic [31:0] want,
			input logic [31:0] got);
		if (got !== want) begin
			mismatch_count++;
			if (mismatch_count <= 10)
				$display("checker: %s mismatch, expected %0h, got %0h", name, want, got);
		end
	endtask

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tile_w = TILE_W'(8);
			tile_h = TILE_W'(8);
			key_thr = CNT_W'(3);
			hold_thr = CNT_W'(15);
			prev_code = '0;
			press_code = '0;
			key_run = '0;
			still_run = '0;
			touch_prev = 1'b0;
			col_now = '0;
			row_now = '0;
			col_origin = '0;
			row_origin = '0;
			tap_cell_col = '0;
			tap_cell_row = '0;
			delta_x = '0;
			delta_y = '0;
			dragging = 1'b0;
			drag_begun = 1'b0;
			drag_ended = 1'b0;
			holding = 1'b0;
			predicted_results.delete();
			mismatch_count = 0;
			outstanding = 0;
		end else begin
			// compare first: a result never belongs to a frame taken on the same edge
			if (m_tvalid && m_tready) begin
				got_res = m_tdata[RES_W-1:0];
				if (predicted_results.size() == 0) begin
					mismatch_count++;
					if (mismatch_count <= 10)
						$display("checker: result %0h with no frame pending", got_res);
				end else begin
					want_res = predicted_results.pop_front();
					check_field("held_code", want_res.held_code, got_res.held_code);
					check_field("pressed_code", want_res.pressed_code, got_res.pressed_code);
					check_field("released_keys", want_res.released_keys,
						got_res.released_keys);
					check_field("touch_col", want_res.touch_col, got_res.touch_col);
					check_field("touch_row", want_res.touch_row, got_res.touch_row);
					check_field("drag_dx", want_res.drag_dx, got_res.drag_dx);
					check_field("drag_dy", want_res.drag_dy, got_res.drag_dy);
					check_field("tap_col", want_res.tap_col, got_res.tap_col);
					check_field("tap_row", want_res.tap_row, got_res.tap_row);
					check_field("gesture_flags", want_res.gesture_flags,
						got_res.gesture_flags);
				end
			end
			if (cfg_valid && cfg_ready) begin
				case (cfg_idx_t'(cfg_index))
					CFG_TILE_WIDTH:  tile_w = cfg_data[TILE_W-1:0];
					CFG_TILE_HEIGHT: tile_h = cfg_data[TILE_W-1:0];
					CFG_KEY_HOLD:    key_thr = cfg_data;
					CFG_TOUCH_HOLD:  hold_thr = cfg_data;
					default: ;
				endcase
			end
			if (s_tvalid && s_tready)
				predicted_results.push_back(qualify_frame(s_tdata, s_tuser));
			outstanding = predicted_results.size();
		end
	end

endmodule

// ===== tb/testbench.sv =====
// Top of the gesture qualifier testbench: clock, reset, frame and register
// stimulus, result-side back-pressure and the final verdict.
// Depends on btgq_pkg, button_touch_gesture_qualifier_core and btgq_result_checker.
`timescale 1ns / 1ps

module testbench;
	import btgq_pkg::*;

	// single pad buttons, placed by the package key positions
	localparam logic [KEY_W-1:0] PAD_RIGHT = KEY_W'(1) << BIT_PAD_RIGHT;
	localparam logic [KEY_W-1:0] PAD_LEFT  = KEY_W'(1) << BIT_PAD_LEFT;
	localparam logic [KEY_W-1:0] PAD_UP    = KEY_W'(1) << BIT_PAD_UP;
	localparam logic [KEY_W-1:0] PAD_DOWN  = KEY_W'(1) << BIT_PAD_DOWN;
	localparam logic [KEY_W-1:0] BTN_TOUCH = KEY_W'(1) << BIT_SCREEN_TOUCH;
	localparam logic [KEY_W-1:0] BTN_A     = KEY_W'(1);

	logic         clk = 1'b0;
	logic         arst_n;
	logic         s_tvalid;
	logic         s_tready;
	logic [63:0]  s_tdata;
	logic         s_tuser;
	logic         m_tvalid;
	logic         m_tready;
	logic [111:0] m_tdata;
	logic         cfg_valid;
	logic         cfg_ready;
	logic [1:0]   cfg_index;
	logic [7:0]   cfg_data;

	int   mismatch_count;
	int   outstanding;
	int   sent_frames = 0;
	// steady: both sides run without gaps for the whole phase
	logic steady = 1'b0;
	// thresholds in force, used only to size the hold sequences
	int   key_thr_now = 3;
	int   hold_thr_now = 15;

	always #4 clk = ~clk;

	button_touch_gesture_qualifier_core u_top (
		.clk       (clk),
		.arst_n    (arst_n),
		.s_tvalid  (s_tvalid),
		.s_tready  (s_tready),
		.s_tdata   (s_tdata),
		.s_tuser   (s_tuser),
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.m_tdata   (m_tdata),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data)
	);

	btgq_result_checker u_check (
		.clk            (clk),
		.arst_n         (arst_n),
		.s_tvalid       (s_tvalid),
		.s_tready       (s_tready),
		.s_tdata        (s_tdata),
		.s_tuser        (s_tuser),
		.m_tvalid       (m_tvalid),
		.m_tready       (m_tready),
		.m_tdata        (m_tdata),
		.cfg_valid      (cfg_valid),
		.cfg_ready      (cfg_ready),
		.cfg_index      (cfg_index),
		.cfg_data       (cfg_data),
		.mismatch_count (mismatch_count),
		.outstanding    (outstanding)
	);

	// Send one frame. Entered and left on a falling edge; valid stays high on
	// exit so a back-to-back frame replaces the data without a low cycle.
	task automatic send_frame(input logic [KEY_W-1:0] held, input logic [KEY_W-1:0] rel,
			input logic [7:0] tx, input logic [7:0] ty, input logic tv,
			input logic [7:0] px, input logic [7:0] py);
		int gap;
		gap = steady ? 0 : $urandom_range(0, 8);
		if (gap > 0) begin
			s_tvalid <= 1'b0;
			repeat (gap) @(negedge clk);
		end
		s_tdata <= {4'b0, py, px, ty, tx, rel, held};
		s_tuser <= tv;
		s_tvalid <= 1'b1;
		do @(posedge clk); while (!s_tready);
		@(negedge clk);
		sent_frames++;
	endtask

	// Drop valid and wait until every frame has produced its result.
	task automatic drain();
		s_tvalid <= 1'b0;
		wait (outstanding == 0);
		repeat (4) @(negedge clk);
	endtask

	// Write all four registers as back-to-back transfers; the block is idle here.
	task automatic write_settings(input logic [7:0] tw, input logic [7:0] th,
			input logic [7:0] kh, input logic [7:0] thr);
		logic [7:0] vals[4];
		vals = '{tw, th, kh, thr};
		for (int i = 0; i < 4; i++) begin
			cfg_valid <= 1'b1;
			cfg_index <= cfg_idx_t'(i);
			cfg_data <= vals[i];
			do @(posedge clk); while (!cfg_ready);
			@(negedge clk);
		end
		cfg_valid <= 1'b0;
		key_thr_now = kh;
		hold_thr_now = thr;
	endtask

	// One key code held for a stretch of frames, with the touch either off,
	// still, dragging around, or random noise. Lengths follow the thresholds
	// so presses and press-and-hold actually qualify.
	task automatic play_episode();
		logic [KEY_W-1:0] keys;
		logic             touch;
		int               len, cap, tmode, x, y;
		case ($urandom_range(0, 6))
			0: keys = '0;
			1: keys = KEY_W'(1) << $urandom_range(0, KEY_W - 1);
			2, 3: begin
				case ($urandom_range(0, 3))
					0: keys = PAD_UP | PAD_LEFT;
					1: keys = PAD_UP | PAD_RIGHT;
					2: keys = PAD_DOWN | PAD_LEFT;
					default: keys = PAD_DOWN | PAD_RIGHT;
				endcase
				// extra bits may add a higher-priority diagonal
				if ($urandom_range(0, 1))
					keys |= KEY_W'($urandom);
			end
			4: keys = PAD_UP | PAD_DOWN | PAD_LEFT | PAD_RIGHT;
			default: keys = KEY_W'($urandom);
		endcase
		cap = (key_thr_now > hold_thr_now) ? key_thr_now : hold_thr_now;
		if (cap > 24)
			cap = 24;
		len = $urandom_range(1, cap + 4);
		tmode = $urandom_range(0, 4);
		x = $urandom_range(0, 255);
		y = $urandom_range(0, 191);
		for (int i = 0; i < len; i++) begin
			touch = (tmode != 0);
			if ((tmode == 2 || tmode == 3) && i > 0 && $urandom_range(0, 3) != 0) begin
				x += int'($urandom_range(0, 48)) - 24;
				y += int'($urandom_range(0, 48)) - 24;
				if (x < 0) x = 0;
				if (x > 255) x = 255;
				if (y < 0) y = 0;
				if (y > 191) y = 191;
			end
			if (tmode == 4) begin
				touch = 1'($urandom_range(0, 1));
				x = $urandom_range(0, 255);
				y = $urandom_range(0, 255);
			end
			keys[BIT_SCREEN_TOUCH] = touch;
			send_frame(keys, KEY_W'($urandom), 8'(x), 8'(y), ($urandom_range(0, 3) == 0),
				8'($urandom), (tmode == 4) ? 8'($urandom) : 8'($urandom_range(0, 191)));
		end
	endtask

	// Reprogram while idle, optionally hold A plus a still touch for a long
	// stretch, then run random episodes.
	task automatic run_phase(input logic [7:0] tw, input logic [7:0] th,
			input logic [7:0] kh, input logic [7:0] thr, input int still_frames,
			input int count);
		int start;
		drain();
		write_settings(tw, th, kh, thr);
		steady = ($urandom_range(0, 3) == 0);
		for (int i = 0; i < still_frames; i++)
			send_frame(BTN_A | BTN_TOUCH, KEY_W'($urandom), 8'd200, 8'd150,
				($urandom_range(0, 7) == 0), 8'($urandom), 8'($urandom_range(0, 191)));
		start = sent_frames;
		while (sent_frames - start < count)
			play_episode();
	endtask

	// Result side: stall a random number of cycles before each transfer.
	initial begin
		m_tready = 1'b0;
		wait (arst_n === 1'b1);
		@(negedge clk);
		forever begin
			int stall;
			stall = steady ? 0 : $urandom_range(0, 8);
			if (stall > 0) begin
				m_tready <= 1'b0;
				repeat (stall) @(negedge clk);
			end
			m_tready <= 1'b1;
			do @(posedge clk); while (!m_tvalid);
			@(negedge clk);
		end
	end

	initial begin
		arst_n = 1'b0;
		s_tvalid = 1'b0;
		s_tdata = '0;
		s_tuser = 1'b0;
		cfg_valid = 1'b0;
		cfg_index = CFG_TILE_WIDTH;
		cfg_data = '0;
		repeat (6) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// Directed frames at the reset settings.
		send_frame('0, '0, 8'd0, 8'd0, 1'b0, 8'd0, 8'd0);
		// everything held: up+left wins, first touch, tap on the touch-down frame
		send_frame('1, '1, 8'd255, 8'd191, 1'b1, 8'd255, 8'd191);
		send_frame(PAD_UP | PAD_RIGHT, '0, 8'd0, 8'd0, 1'b0, 8'd0, 8'd0);
		send_frame(PAD_DOWN | PAD_LEFT, '1, 8'd0, 8'd0, 1'b0, 8'd0, 8'd0);
		send_frame(PAD_DOWN | PAD_RIGHT, '0, 8'd0, 8'd0, 1'b0, 8'd0, 8'd0);
		// A held long enough to qualify, then let go
		repeat (5)
			send_frame(BTN_A, '0, 8'd0, 8'd0, 1'b0, 8'd0, 8'd0);
		send_frame('0, BTN_A, 8'd0, 8'd0, 1'b0, 8'd0, 8'd0);
		// still touch, drag start with a suppressed tap, drag on, release, then a tap
		send_frame(BTN_TOUCH, '0, 8'd0, 8'd0, 1'b0, 8'd0, 8'd0);
		send_frame(BTN_TOUCH, '0, 8'd0, 8'd0, 1'b0, 8'd0, 8'd0);
		send_frame(BTN_TOUCH, '0, 8'd100, 8'd50, 1'b1, 8'd100, 8'd50);
		send_frame(BTN_TOUCH, '0, 8'd120, 8'd60, 1'b0, 8'd0, 8'd0);
		send_frame(BTN_TOUCH, '0, 8'd120, 8'd60, 1'b0, 8'd0, 8'd0);
		send_frame('0, '0, 8'd7, 8'd7, 1'b1, 8'd40, 8'd30);
		send_frame('0, '0, 8'd7, 8'd7, 1'b1, 8'd64, 8'd128);
		send_frame('0, '0, 8'd0, 8'd0, 1'b0, 8'd0, 8'd0);

		// Random part: defaults first, then the extremes, then random settings.
		while (sent_frames < 60)
			play_episode();
		run_phase(8'd0, 8'd0, 8'd0, 8'd0, 0, 60);
		run_phase(8'd32, 8'd32, 8'd1, 8'd2, 0, 60);
		run_phase(8'd63, 8'd1, 8'd5, 8'd8, 0, 60);
		// long still press: both frame counters run into saturation
		run_phase(8'd1, 8'd63, 8'd254, 8'd255, 262, 20);
		// upper data bits beyond the tile width are dropped
		run_phase(8'hC5, 8'h48, 8'd255, 8'd0, 0, 40);
		while (sent_frames < 680)
			run_phase(8'($urandom), 8'($urandom), 8'($urandom_range(0, 8)),
				8'($urandom_range(0, 8)), 0, 50);

		s_tvalid <= 1'b0;
		wait (outstanding == 0);
		repeat (40) @(negedge clk);
		if (mismatch_count == 0)
			$display("testbench: done, clean");
		else
			$display("testbench: done, errors");
		$finish;
	end

	initial begin
		#2_000_000;
		$display("testbench: done, errors");
		$finish;
	end

endmodule

// ===== sim.f =====
+incdir+src
src/btgq_pkg.sv
src/btgq_div.sv
src/btgq_track.sv
src/button_touch_gesture_qualifier_core.sv
tb/btgq_result_checker.sv
tb/testbench.sv
